// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the table engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition is never seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/bate_pkg.sv =====
// Shared types and codes of the bounded table engine.
package bate_pkg;

  // Operation carried with each input item
  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_MODIFY  = 3'd2,
    OP_SORT    = 3'd3,
    OP_LSEARCH = 3'd4,
    OP_BSEARCH = 3'd5,
    OP_DUMP    = 3'd6
  } opcode_t;

  // Result status
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NEG      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // What every cell of the chain does next
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_SORT_EVEN,
    CM_SORT_ODD
  } cell_mode_t;

  localparam int DATA_W = 32;
  localparam int OUT_IDX_W = 4;

endpackage

// ===== hw/rtl/bate_cell.sv =====
// One table cell: holds an entry, rotates towards cell zero or swaps with a neighbour.
module bate_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  bate_pkg::cell_mode_t          mode,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [bate_pkg::DATA_W-1:0] left_val,
  input  logic signed [bate_pkg::DATA_W-1:0] right_val,
  output logic signed [bate_pkg::DATA_W-1:0] val
);
  import bate_pkg::*;

  localparam bit EVEN_IDX = (IDX % 2) == 0;
  localparam bit HAS_LEFT = IDX > 0;
  localparam logic [CNT_W:0] IDX_OWN  = (CNT_W + 1)'(IDX);
  localparam logic [CNT_W:0] IDX_NEXT = (CNT_W + 1)'(IDX + 1);

  logic signed [DATA_W-1:0] val_next;
  logic                     left_role;
  logic                     right_live;
  logic                     left_live;

  // Pick the next content of the cell
  always_comb begin
    left_role  = ((mode == CM_SORT_EVEN) == EVEN_IDX);
    right_live = IDX_NEXT < {1'b0, count};
    left_live  = HAS_LEFT && (IDX_OWN < {1'b0, count});
    val_next   = val;
    case (mode)
      CM_ROTATE: val_next = right_val;
      CM_SORT_EVEN, CM_SORT_ODD: begin
        if (left_role) begin
          if (right_live && (val > right_val)) val_next = right_val;
        end else begin
          if (left_live && (left_val > val)) val_next = left_val;
        end
      end
      default: val_next = val;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== hw/rtl/bounded_array_table_engine.sv =====
// Top level of the bounded table engine: controller and chain of table cells.
// The table lives in a ring of CAPACITY cells that rotates one place per cycle towards
// cell zero unless a dump is held by a stalled output; at cell zero the controller reads,
// adds, rewrites or drops entries on the fly. A full turn brings every entry back to its
// place, but the entries behind a deleted one move one place down. Insert, delete, modify
// and linear search take a full turn plus accept and result, sort takes CAPACITY odd-even
// exchange phases between neighbouring cells, binary search takes a full turn for each
// probe, up to floor(log2(entry_count)) + 1 probes, and dump takes a full turn, held
// while the output is stalled. Insert when full, insert of a negative value, an unused
// code, and sort or dump of an empty table answer without a turn. Any item also waits in
// its result state while the previous result is still held in the output register.
// The table needs no clearing after reset.
// At most one item is in work at a time; the output register lets the next item be taken
// while the last result still waits.
module bounded_array_table_engine #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] value, [63:32] new_value
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] found_index, [35:4] entry_value, [39:36] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast
);
  import bate_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = CW + 1;
  localparam int BW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SORT, S_BNEXT, S_PROBE, S_BCMP, S_DUMP, S_RESULT
  } state_t;

  state_t                   state;
  opcode_t                  op;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] nval;
  logic [CW-1:0]            count;
  logic [IW-1:0]            k;
  logic                     found;
  logic [IW-1:0]            hit;
  logic signed [BW-1:0]     lo;
  logic signed [BW-1:0]     hi;
  logic [IW-1:0]            mid;
  logic signed [DATA_W-1:0] probe;
  status_t                  res_status;
  logic [OUT_IDX_W-1:0]     res_idx;
  status_t                  out_status;
  logic [OUT_IDX_W-1:0]     out_idx;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] head;
  logic signed [DATA_W-1:0] nxt;
  logic signed [DATA_W-1:0] feed;
  cell_mode_t               mode;
  logic                     slot_free;
  logic                     advance;
  logic                     out_load;
  logic [KW-1:0]            k_ext;
  logic [KW-1:0]            cnt_ext;
  logic                     k_in;
  logic                     k_last;
  logic                     match;
  logic                     hit_any;
  logic signed [BW:0]       bsum;
  opcode_t                  in_op;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_new;

  assign in_op    = opcode_t'(s_tuser);
  assign in_value = s_tdata[31:0];
  assign in_new   = s_tdata[63:32];

  assign head      = cell_val[0];
  assign nxt       = cell_val[1];
  assign slot_free = !m_tvalid || m_tready;
  assign k_ext     = KW'(k);
  assign cnt_ext   = {1'b0, count};
  assign k_in      = k_ext < cnt_ext;
  assign k_last    = (k == IW'(CAPACITY - 1));
  assign match     = k_in && !found && (head == key);
  assign hit_any   = found || match;
  assign bsum      = (BW + 1)'(lo) + (BW + 1)'(hi);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {4'b0, out_value, out_idx};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // Step the ring when the current state lets it
  always_comb begin
    case (state)
      S_SCAN, S_PROBE, S_SORT: advance = 1'b1;
      S_DUMP:                  advance = !k_in || slot_free;
      default:                 advance = 1'b0;
    endcase
  end

  // Load the output register with a new result this cycle
  assign out_load = ((state == S_RESULT) && slot_free) ||
                    ((state == S_DUMP) && advance && k_in);

  // Choose what enters the tail of the ring
  always_comb begin
    feed = head;
    if (state == S_SCAN) begin
      case (op)
        OP_INSERT: feed = (k_ext == cnt_ext) ? key : head;
        OP_DELETE: feed = hit_any ? nxt : head;
        OP_MODIFY: feed = match ? nval : head;
        default:   feed = head;
      endcase
    end
  end

  // Tell the cells what to do
  always_comb begin
    case (state)
      S_SCAN, S_PROBE, S_DUMP: mode = advance ? CM_ROTATE : CM_HOLD;
      S_SORT:                  mode = k[0] ? CM_SORT_ODD : CM_SORT_EVEN;
      default:                 mode = CM_HOLD;
    endcase
  end

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    assign left_in  = (i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i - 1];
    assign right_in = (i == CAPACITY - 1) ? feed
                                          : cell_val[(i == CAPACITY - 1) ? i : i + 1];
    bate_cell #(
      .IDX   (i),
      .CNT_W (CW)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .count     (count),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_val[i])
    );
  end

  // Sequence the operations and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= in_op;
            key     <= in_value;
            nval    <= in_new;
            k       <= '0;
            found   <= 1'b0;
            res_idx <= '0;
            case (in_op)
              OP_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state      <= S_RESULT;
                end else if (in_value < 0) begin
                  res_status <= ST_NEG;
                  state      <= S_RESULT;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_DELETE, OP_MODIFY, OP_LSEARCH: state <= S_SCAN;
              OP_SORT: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESULT;
                end else begin
                  state <= S_SORT;
                end
              end
              OP_BSEARCH: begin
                lo    <= '0;
                hi    <= BW'(count) - BW'(1);
                state <= S_BNEXT;
              end
              OP_DUMP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESULT;
                end else begin
                  state <= S_DUMP;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_RESULT;
              end
            endcase
          end
        end
        S_SCAN: begin
          k <= k + IW'(1);
          if (match) begin
            found <= 1'b1;
            hit   <= k;
          end
          if (k_last) begin
            state <= S_RESULT;
            case (op)
              OP_INSERT: begin
                res_status <= ST_OK;
                count      <= count + CW'(1);
              end
              OP_DELETE: begin
                res_status <= hit_any ? ST_OK : ST_NOTFOUND;
                if (hit_any) count <= count - CW'(1);
              end
              OP_MODIFY: res_status <= hit_any ? ST_OK : ST_NOTFOUND;
              default: begin
                res_status <= hit_any ? ST_OK : ST_NOTFOUND;
                if (hit_any) res_idx <= OUT_IDX_W'(match ? k : hit);
              end
            endcase
          end
        end
        S_SORT: begin
          k <= k + IW'(1);
          if (k_last) begin
            res_status <= ST_OK;
            state      <= S_RESULT;
          end
        end
        S_BNEXT: begin
          k <= '0;
          if (lo <= hi) begin
            mid   <= IW'(bsum[BW:1]);
            state <= S_PROBE;
          end else begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESULT;
          end
        end
        S_PROBE: begin
          k <= k + IW'(1);
          if (k == mid) probe <= head;
          if (k_last) state <= S_BCMP;
        end
        S_BCMP: begin
          if (probe == key) begin
            res_status <= ST_OK;
            res_idx    <= OUT_IDX_W'(mid);
            state      <= S_RESULT;
          end else if (probe < key) begin
            lo    <= BW'(BW'(mid) + BW'(1));
            state <= S_BNEXT;
          end else begin
            hi    <= BW'(BW'(mid) - BW'(1));
            state <= S_BNEXT;
          end
        end
        S_DUMP: begin
          if (advance) begin
            if (k_in) begin
              m_tvalid   <= 1'b1;
              out_status <= ST_OK;
              out_idx    <= OUT_IDX_W'(k);
              out_value  <= head;
              out_last   <= (KW'(k_ext + KW'(1)) == cnt_ext);
            end
            k <= k + IW'(1);
            if (k_last) state <= S_IDLE;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_idx    <= res_idx;
            out_value  <= '0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_count_bound, clk, rst, count > CW'(CAPACITY), "entry count above capacity")
  `ASSERT_PROP(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "accepted item left engine idle")
  `ASSERT_PROP(a_count_only_scan, clk, rst, (state != S_SCAN) |=> $stable(count), "entry count changed outside a scan")
  `ASSERT_PROP(a_nonlast_is_dump, clk, rst, (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK), "non-final result without ok status")
  `ASSERT_PROP(a_ring_holds_idle, clk, rst, (state == S_IDLE) |-> (mode == CM_HOLD), "cell chain moved while idle")

endmodule

// ===== dv/bounded_array_table_engine_test.sv =====
// Self-checking stream testbench for the bounded table engine.
module bounded_array_table_engine_test;
  import bate_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int PHASE_COUNT = 4;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int TREND_SPAN = 30;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;

  // One awaited result
  typedef struct {
    status_t     status;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } table_result_t;

  // Table shadow and queue of awaited results
  class table_scoreboard;
    logic signed [31:0] cells [DEPTH];
    int fill;
    table_result_t awaited [$];
    int errors;
    int result_count;
    int op_count [8];

    function new();
      fill = 0;
      errors = 0;
      result_count = 0;
      foreach (op_count[k]) op_count[k] = 0;
    endfunction

    // Index of the first entry equal to v, or fill when absent
    function int locate(logic signed [31:0] v);
      int i;
      for (i = 0; i < fill; i++)
        if (cells[i] == v) return i;
      return fill;
    endfunction

    function void await_result(status_t st, int idx, logic [31:0] val, logic last);
      table_result_t r;
      r.status = st;
      r.index = 4'(idx);
      r.value = val;
      r.last = last;
      awaited.push_back(r);
    endfunction

    // Apply one accepted item to the shadow table and queue its results
    function void note(logic [2:0] op, logic signed [31:0] v, logic signed [31:0] nv);
      int pos, i, j, lo, hi, mid;
      logic signed [31:0] key;
      bit hit;
      op_count[op]++;
      case (op)
        OP_INSERT: begin
          if (fill >= DEPTH) begin
            await_result(ST_FULL, 0, '0, 1'b1);
          end else if (v < 0) begin
            await_result(ST_NEG, 0, '0, 1'b1);
          end else begin
            cells[fill] = v;
            fill++;
            await_result(ST_OK, 0, '0, 1'b1);
          end
        end
        OP_DELETE: begin
          pos = locate(v);
          if (pos >= fill) begin
            await_result(ST_NOTFOUND, 0, '0, 1'b1);
          end else begin
            for (j = pos; j + 1 < fill; j++) cells[j] = cells[j + 1];
            fill--;
            await_result(ST_OK, 0, '0, 1'b1);
          end
        end
        OP_MODIFY: begin
          pos = locate(v);
          if (pos >= fill) begin
            await_result(ST_NOTFOUND, 0, '0, 1'b1);
          end else begin
            cells[pos] = nv;
            await_result(ST_OK, 0, '0, 1'b1);
          end
        end
        OP_SORT: begin
          if (fill == 0) begin
            await_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (i = 1; i < fill; i++) begin
              key = cells[i];
              j = i;
              while (j > 0 && cells[j - 1] > key) begin
                cells[j] = cells[j - 1];
                j--;
              end
              cells[j] = key;
            end
            await_result(ST_OK, 0, '0, 1'b1);
          end
        end
        OP_LSEARCH: begin
          pos = locate(v);
          if (pos >= fill) await_result(ST_NOTFOUND, 0, '0, 1'b1);
          else await_result(ST_OK, pos, '0, 1'b1);
        end
        OP_BSEARCH: begin
          // bisect the table as it stands, sorted or not
          lo = 0;
          hi = fill - 1;
          hit = 1'b0;
          mid = 0;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (cells[mid] == v) hit = 1'b1;
            else if (cells[mid] < v) lo = mid + 1;
            else hi = mid - 1;
          end
          if (hit) await_result(ST_OK, mid, '0, 1'b1);
          else await_result(ST_NOTFOUND, 0, '0, 1'b1);
        end
        OP_DUMP: begin
          if (fill == 0) begin
            await_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) await_result(ST_OK, i, cells[i], i + 1 == fill);
          end
        end
        default: begin
          // spare code leaves the table alone
          await_result(ST_OK, 0, '0, 1'b1);
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest awaited one
    function void check(logic [2:0] st, logic [3:0] idx, logic [31:0] val, logic last);
      table_result_t e;
      result_count++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d index %0d value %0d last %0d",
                 $time, st, idx, $signed(val), last);
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status || idx !== e.index || val !== e.value || last !== e.last) begin
        errors++;
        $display("%0t: mismatch: expected status %0d index %0d value %0d last %0d",
                 $time, e.status, e.index, $signed(e.value), e.last);
        $display("%0t:           got      status %0d index %0d value %0d last %0d",
                 $time, st, idx, $signed(val), last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  table_scoreboard board;

  bounded_array_table_engine #(.CAPACITY(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready)
      board.check(m_tuser, m_tdata[3:0], m_tdata[35:4], m_tlast);
  end

  // Abandon a hung run
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(logic [2:0] op, logic signed [31:0] v, logic signed [31:0] nv);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {nv, v};
    do @(posedge clk); while (!s_tready);
    board.note(op, v, nv);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (board.awaited.size() != 0) @(negedge clk);
  endtask

  // Operand that mostly hits the table, sometimes misses or spans the full range
  function automatic logic signed [31:0] pick_operand();
    int r;
    r = $urandom_range(99);
    if (board.fill > 0 && r < 65) return board.cells[$urandom_range(board.fill - 1)];
    if (r < 80) return $urandom_range(40);
    if (r < 88) return -$urandom_range(1, 40);
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_insert_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return {1'b1, 31'($urandom)};
    if (r < 20) return {1'b0, 31'($urandom)};
    return $urandom_range(60);
  endfunction

  // One random item; grow tilts the mix towards inserts, else towards deletes
  task automatic send_random_item(bit grow);
    int r, ins_w, del_w;
    logic [2:0] op;
    ins_w = grow ? 45 : 15;
    del_w = grow ? 10 : 35;
    r = $urandom_range(99);
    if (r < ins_w) begin
      send_item(OP_INSERT, pick_insert_value(), $urandom);
    end else if (r < ins_w + del_w) begin
      send_item(OP_DELETE, pick_operand(), $urandom);
    end else begin
      r = $urandom_range(99);
      if (r < 20) op = OP_MODIFY;
      else if (r < 35) op = OP_SORT;
      else if (r < 55) op = OP_LSEARCH;
      else if (r < 80) op = OP_BSEARCH;
      else if (r < 94) op = OP_DUMP;
      else op = OP_SPARE;
      send_item(op, pick_operand(), (op == OP_MODIFY) ? pick_operand() : $urandom);
    end
  endtask

  initial begin
    int k, phase;
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table, rejected values, spare code, filling up and overflow, then work on the full table
    send_item(OP_DUMP, 32'sd0, 32'sd0);
    send_item(OP_SORT, 32'sd0, 32'sd0);
    send_item(OP_BSEARCH, 32'sd5, 32'sd0);
    send_item(OP_DELETE, 32'sd5, 32'sd0);
    send_item(OP_INSERT, 32'sh8000_0000, 32'sd0);
    send_item(OP_SPARE, 32'shffff_ffff, 32'shffff_ffff);
    send_item(OP_INSERT, 32'sd0, 32'sd0);
    send_item(OP_INSERT, 32'sh7fff_ffff, 32'sd0);
    for (k = 0; k < DEPTH - 2; k++) send_item(OP_INSERT, (k * 11) % 13, 32'sd0);
    send_item(OP_INSERT, 32'sd9, 32'sd0);
    send_item(OP_BSEARCH, 32'sd3, 32'sd0);
    send_item(OP_SORT, 32'sd0, 32'sd0);
    send_item(OP_DUMP, 32'sd0, 32'sd0);
    send_item(OP_BSEARCH, 32'sh7fff_ffff, 32'sd0);
    send_item(OP_MODIFY, 32'sd0, 32'sh8000_0000);
    send_item(OP_DELETE, 32'sh7fff_ffff, 32'sd0);
    send_item(OP_LSEARCH, 32'sh8000_0000, 32'sd0);

    // Random phases under different idle and stall mixes
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      wait_drained();
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 52; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 52; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        send_random_item(((k / TREND_SPAN) + phase) % 2 == 0);
    end

    // Drain and report
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d inserts, %0d deletes, %0d modifies, %0d sorts, %0d linear searches,",
             board.op_count[OP_INSERT], board.op_count[OP_DELETE],
             board.op_count[OP_MODIFY], board.op_count[OP_SORT], board.op_count[OP_LSEARCH]);
    $display("%0d binary searches, %0d dumps, %0d spare codes; %0d results, %0d mismatches",
             board.op_count[OP_BSEARCH], board.op_count[OP_DUMP], board.op_count[OP_SPARE],
             board.result_count, board.errors);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
